FILE: rtl/adcst_pkg.sv
// ----------------------------------------------------------------------------
// adcst_pkg
// Types and constants shared by the supply/temperature sequencer and its
// serial arithmetic unit.
// ----------------------------------------------------------------------------
package adcst_pkg;

  // Field and register widths
  localparam int unsigned ADC_BITS   = 12;
  localparam int unsigned PRESC_W    = 16;
  localparam int unsigned VREF_W     = 22;
  localparam int unsigned SLOPE_W    = 16;
  localparam int unsigned CFG_W      = 22;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SUPPLY_W   = 16;
  localparam int unsigned TEMP_W     = 12;

  // Datapath widths
  localparam int unsigned PROD_W     = VREF_W + ADC_BITS;       // uV * sample
  localparam int unsigned DEN_W      = SLOPE_W + ADC_BITS;      // slope * ref
  localparam int unsigned MAG_W      = PROD_W + 4;              // times ten
  localparam int unsigned D1_W       = ADC_BITS + 10;           // ref * 1000
  localparam int unsigned SUP_Q_BITS = SUPPLY_W;
  localparam int unsigned TMP_Q_BITS = 11;
  localparam int unsigned DSH1_W     = D1_W + SUP_Q_BITS;
  localparam int unsigned DSH2_W     = DEN_W + TMP_Q_BITS;
  localparam int unsigned STEP_W     = 5;

  localparam logic [ADC_BITS-1:0]   FULL_SCALE   = '1;
  localparam logic [TMP_Q_BITS:0]   TEMP_POS_CAP = 12'd1750;
  localparam logic [TMP_Q_BITS:0]   TEMP_NEG_CAP = 12'd1250;
  localparam logic [TMP_Q_BITS+1:0] TEMP_OFFSET  = 13'd250;

  // Register reset values
  localparam logic [PRESC_W-1:0] PRESC_RESET = 16'd500;
  localparam logic [VREF_W-1:0]  VREF_RESET  = 22'd1200000;
  localparam logic [VREF_W-1:0]  V25_RESET   = 22'd1430000;
  localparam logic [SLOPE_W-1:0] SLOPE_RESET = 16'd4300;

  localparam logic [1:0] EVT_START         = 2'd1;
  localparam logic [1:0] EVT_FAULT_CLEARED = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESCALE = 2'd0,
    CFG_VREF     = 2'd1,
    CFG_V25      = 2'd2,
    CFG_SLOPE    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_EVENT = 2'd1,
    CMD_CONV  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_OK    = 2'd1,
    KIND_FAIL  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_WAITING = 2'd1,
    MODE_FAULT   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CALC,
    SEQ_EMIT
  } seq_state_e;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_MUL,
    AR_PREP,
    AR_DIV,
    AR_FIN
  } arith_state_e;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [1:0]          event_code;
    logic [ADC_BITS-1:0] temp_sample;
    logic [ADC_BITS-1:0] ref_sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [SUPPLY_W-1:0]      supply_millivolts;
    logic signed [TEMP_W-1:0] temp_decidegrees;
  } out_item_t;

  typedef struct packed {
    logic                     done;
    logic [SUPPLY_W-1:0]      supply_millivolts;
    logic signed [TEMP_W-1:0] temp_decidegrees;
  } arith_res_t;

endpackage

FILE: rtl/adcst_arith.sv
// ----------------------------------------------------------------------------
// adcst_arith
// Bit-serial measurement unit: shift-and-add products over the sample bits,
// then restoring division for supply and temperature, one bit per cycle.
// ----------------------------------------------------------------------------
module adcst_arith (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [adcst_pkg::ADC_BITS-1:0] ref_sample_i,
  input  logic [adcst_pkg::ADC_BITS-1:0] temp_sample_i,
  input  logic [adcst_pkg::VREF_W-1:0]  vref_i,
  input  logic [adcst_pkg::VREF_W-1:0]  v25_i,
  input  logic [adcst_pkg::SLOPE_W-1:0] slope_i,
  output adcst_pkg::arith_res_t         res_o
);
  import adcst_pkg::*;

  arith_state_e st_q, st_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [ADC_BITS-1:0]   ref_sh_q, tmp_sh_q;
  logic [PROD_W-1:0]     acc_v25_q, acc_vt_q;
  logic [DEN_W-1:0]      acc_den_q;
  logic [PROD_W-1:0]     rem1_q;
  logic [DSH1_W-1:0]     dsh1_q;
  logic [SUP_Q_BITS:0]   quo1_q;
  logic [MAG_W-1:0]      rem2_q;
  logic [DSH2_W-1:0]     dsh2_q;
  logic [TMP_Q_BITS:0]   quo2_q;
  logic                  sign_q, zero_q;

  logic                  neg;
  logic [PROD_W-1:0]     mag;
  logic [MAG_W-1:0]      mag10;
  logic [PROD_W-1:0]     sup_num;
  logic [D1_W-1:0]       sup_den;
  logic                  ge1, ge2, tmp_en;
  logic [TMP_Q_BITS:0]   tq_cap;
  logic [TMP_Q_BITS+1:0] t_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= AR_IDLE;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
    end
  end

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    case (st_q)
      AR_IDLE: begin
        if (start_i) begin
          st_d   = AR_MUL;
          step_d = STEP_W'(ADC_BITS - 1);
        end
      end
      AR_MUL: begin
        if (step_q == '0) begin
          st_d = AR_PREP;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      AR_PREP: begin
        st_d   = AR_DIV;
        step_d = STEP_W'(SUP_Q_BITS);
      end
      AR_DIV: begin
        if (step_q == '0) begin
          st_d = AR_FIN;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      AR_FIN: st_d = AR_IDLE;
      default: st_d = AR_IDLE;
    endcase
  end

  // Operand preparation
  assign neg     = acc_vt_q > acc_v25_q;
  assign mag     = neg ? (acc_vt_q - acc_v25_q) : (acc_v25_q - acc_vt_q);
  assign mag10   = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
  assign sup_num = {vref_i, {ADC_BITS{1'b0}}} - {{ADC_BITS{1'b0}}, vref_i};
  // ref * 1000 = ref * 1024 - ref * 16 - ref * 8
  assign sup_den = {ref_sh_q, 10'b0} - {6'b0, ref_sh_q, 4'b0} - {7'b0, ref_sh_q, 3'b0};

  assign ge1    = {{(DSH1_W-PROD_W){1'b0}}, rem1_q} >= dsh1_q;
  assign ge2    = {{(DSH2_W-MAG_W){1'b0}}, rem2_q} >= dsh2_q;
  assign tmp_en = step_q <= STEP_W'(TMP_Q_BITS);

  always_ff @(posedge clk_i) begin
    case (st_q)
      AR_IDLE: begin
        if (start_i) begin
          ref_sh_q  <= ref_sample_i;
          tmp_sh_q  <= temp_sample_i;
          acc_v25_q <= '0;
          acc_vt_q  <= '0;
          acc_den_q <= '0;
        end
      end
      AR_MUL: begin
        // rotate ref so it is back in place for the divisor setup
        ref_sh_q  <= {ref_sh_q[ADC_BITS-2:0], ref_sh_q[ADC_BITS-1]};
        tmp_sh_q  <= {tmp_sh_q[ADC_BITS-2:0], 1'b0};
        acc_v25_q <= {acc_v25_q[PROD_W-2:0], 1'b0}
                   + (ref_sh_q[ADC_BITS-1] ? {{(PROD_W-VREF_W){1'b0}}, v25_i} : '0);
        acc_vt_q  <= {acc_vt_q[PROD_W-2:0], 1'b0}
                   + (tmp_sh_q[ADC_BITS-1] ? {{(PROD_W-VREF_W){1'b0}}, vref_i} : '0);
        acc_den_q <= {acc_den_q[DEN_W-2:0], 1'b0}
                   + (ref_sh_q[ADC_BITS-1] ? {{(DEN_W-SLOPE_W){1'b0}}, slope_i} : '0);
      end
      AR_PREP: begin
        rem1_q <= sup_num;
        dsh1_q <= {sup_den, {SUP_Q_BITS{1'b0}}};
        quo1_q <= '0;
        rem2_q <= mag10;
        dsh2_q <= {acc_den_q, {TMP_Q_BITS{1'b0}}};
        quo2_q <= '0;
        sign_q <= neg;
        zero_q <= (mag == '0);
      end
      AR_DIV: begin
        // top quotient bit flags overflow, which saturates
        if (ge1) begin
          rem1_q <= rem1_q - dsh1_q[PROD_W-1:0];
        end
        quo1_q <= {quo1_q[SUP_Q_BITS-1:0], ge1};
        dsh1_q <= dsh1_q >> 1;
        if (tmp_en) begin
          if (ge2) begin
            rem2_q <= rem2_q - dsh2_q[MAG_W-1:0];
          end
          quo2_q <= {quo2_q[TMP_Q_BITS-1:0], ge2};
          dsh2_q <= dsh2_q >> 1;
        end
      end
      default: ;
    endcase
  end

  // Saturate and offset the quotients
  always_comb begin
    if (!sign_q) begin
      tq_cap = (quo2_q > TEMP_POS_CAP) ? TEMP_POS_CAP : quo2_q;
    end else begin
      tq_cap = (quo2_q > TEMP_NEG_CAP) ? TEMP_NEG_CAP : quo2_q;
    end
    if (zero_q) begin
      t_val = TEMP_OFFSET;
    end else if (sign_q) begin
      t_val = TEMP_OFFSET - {1'b0, tq_cap};
    end else begin
      t_val = TEMP_OFFSET + {1'b0, tq_cap};
    end
  end

  assign res_o.done              = (st_q == AR_FIN);
  assign res_o.supply_millivolts = quo1_q[SUP_Q_BITS] ? '1 : quo1_q[SUP_Q_BITS-1:0];
  assign res_o.temp_decidegrees  = t_val[TEMP_W-1:0];

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> st_q == AR_IDLE) else $error("start while unit busy");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |-> (res_o.temp_decidegrees >= -12'sd1000 &&
                    res_o.temp_decidegrees <= 12'sd2000))
    else $error("temperature outside saturation range");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == AR_DIV |-> dsh1_q != '0) else $error("supply divisor lost");
`endif

endmodule

FILE: rtl/adc_supply_temperature_sequencer_unit.sv
// ----------------------------------------------------------------------------
// adc_supply_temperature_sequencer_unit
// Tick, event and conversion items are accepted only while the sequencer
// is idle; a start request passes through the emit state into the output
// register once its tick is accepted. A measurement runs the bit-serial
// multiply and the 17-step divider; input stalls meanwhile.
// Reset: idle mode, prescaler zero, registers at defaults, event FIFO empty.
// ----------------------------------------------------------------------------
module adc_supply_temperature_sequencer_unit #(
  parameter int unsigned EVENT_DEPTH = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  adcst_pkg::in_item_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output adcst_pkg::out_item_t            out_data_o,
  input  logic                            cfg_we_i,
  input  logic [adcst_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [adcst_pkg::CFG_W-1:0]     cfg_data_i
);
  import adcst_pkg::*;

  localparam int unsigned PTR_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(EVENT_DEPTH + 1);

  // Configuration
  logic [PRESC_W-1:0] presc_reload_q;
  logic [VREF_W-1:0]  vref_q, v25_q;
  logic [SLOPE_W-1:0] slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_reload_q <= PRESC_RESET;
      vref_q         <= VREF_RESET;
      v25_q          <= V25_RESET;
      slope_q        <= SLOPE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESCALE: presc_reload_q <= cfg_data_i[PRESC_W-1:0];
        CFG_VREF:     vref_q         <= cfg_data_i[VREF_W-1:0];
        CFG_V25:      v25_q          <= cfg_data_i[VREF_W-1:0];
        CFG_SLOPE:    slope_q        <= cfg_data_i[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  seq_state_e          state_q, state_d;
  mode_e               mode_q, mode_d;
  kind_e               kind_q, kind_d;
  logic [PRESC_W-1:0]  presc_q, presc_d;
  logic                pend_q, pend_d;
  logic [1:0]          last_q, last_d;
  logic                conv_q, conv_d;
  logic [ADC_BITS-1:0] held_tmp_q, held_tmp_d;
  logic [ADC_BITS-1:0] held_ref_q, held_ref_d;

  logic [1:0]          fifo_mem_q [EVENT_DEPTH];
  logic [PTR_W-1:0]    head_q, tail_q;
  logic [CNT_W-1:0]    cnt_q;

  logic                in_acc, out_free, push, pop, tick_step, has_evt;
  logic                ev_pend, fault, arith_start;
  logic [1:0]          ev_last;
  logic                out_valid_q;
  out_item_t           out_data_q;
  arith_res_t          arith_res;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(EVENT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall_o = (state_q != SEQ_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign has_evt = (cnt_q != '0);
  assign ev_pend = has_evt || pend_q;
  assign ev_last = has_evt ? fifo_mem_q[head_q] : last_q;
  assign fault   = (held_ref_q == '0) || (held_tmp_q == FULL_SCALE);
  assign push    = in_acc && (in_data_i.cmd == CMD_EVENT)
                   && (cnt_q != CNT_W'(EVENT_DEPTH));
  assign pop     = tick_step && has_evt;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    kind_d      = kind_q;
    presc_d     = presc_q;
    pend_d      = pend_q;
    last_d      = last_q;
    conv_d      = conv_q;
    held_tmp_d  = held_tmp_q;
    held_ref_d  = held_ref_q;
    tick_step   = 1'b0;
    arith_start = 1'b0;
    case (state_q)
      SEQ_IDLE: begin
        if (in_acc) begin
          case (in_data_i.cmd)
            CMD_TICK: begin
              if (presc_q != '0) begin
                presc_d = presc_q - 1'b1;
              end else begin
                presc_d   = presc_reload_q;
                tick_step = 1'b1;
                pend_d    = ev_pend;
                last_d    = ev_last;
                case (mode_q)
                  MODE_IDLE: begin
                    if (ev_pend && ev_last == EVT_START) begin
                      pend_d  = 1'b0;
                      conv_d  = 1'b0;
                      mode_d  = MODE_WAITING;
                      kind_d  = KIND_START;
                      state_d = SEQ_EMIT;
                    end
                  end
                  MODE_WAITING: begin
                    if (conv_q) begin
                      if (fault) begin
                        mode_d  = MODE_FAULT;
                        kind_d  = KIND_FAIL;
                        state_d = SEQ_EMIT;
                      end else begin
                        mode_d      = MODE_IDLE;
                        kind_d      = KIND_OK;
                        arith_start = 1'b1;
                        state_d     = SEQ_CALC;
                      end
                    end
                  end
                  MODE_FAULT: begin
                    if (ev_pend && ev_last == EVT_FAULT_CLEARED) begin
                      pend_d = 1'b0;
                      mode_d = MODE_IDLE;
                    end
                  end
                  default: mode_d = MODE_IDLE;
                endcase
              end
            end
            CMD_CONV: begin
              held_tmp_d = in_data_i.temp_sample;
              held_ref_d = in_data_i.ref_sample;
              conv_d     = 1'b1;
            end
            default: ;
          endcase
        end
      end
      SEQ_CALC: begin
        if (arith_res.done) begin
          state_d = SEQ_EMIT;
        end
      end
      SEQ_EMIT: begin
        if (out_free) begin
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SEQ_IDLE;
      mode_q     <= MODE_IDLE;
      kind_q     <= KIND_START;
      presc_q    <= '0;
      pend_q     <= 1'b0;
      last_q     <= '0;
      conv_q     <= 1'b0;
      held_tmp_q <= '0;
      held_ref_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      kind_q     <= kind_d;
      presc_q    <= presc_d;
      pend_q     <= pend_d;
      last_q     <= last_d;
      conv_q     <= conv_d;
      held_tmp_q <= held_tmp_d;
      held_ref_q <= held_ref_d;
      if (push) begin
        tail_q <= ptr_next(tail_q);
        cnt_q  <= cnt_q + 1'b1;
      end else if (pop) begin
        head_q <= ptr_next(head_q);
        cnt_q  <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem_q[tail_q] <= in_data_i.event_code;
    end
  end

  adcst_arith u_arith (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (arith_start),
    .ref_sample_i  (held_ref_q),
    .temp_sample_i (held_tmp_q),
    .vref_i        (vref_q),
    .v25_i         (v25_q),
    .slope_i       (slope_q),
    .res_o         (arith_res)
  );

  // Output register: load a result when the slot is free or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == SEQ_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SEQ_EMIT && out_free) begin
      out_data_q.kind <= kind_q;
      if (kind_q == KIND_OK) begin
        out_data_q.supply_millivolts <= arith_res.supply_millivolts;
        out_data_q.temp_decidegrees  <= arith_res.temp_decidegrees;
      end else begin
        out_data_q.supply_millivolts <= '0;
        out_data_q.temp_decidegrees  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind != KIND_OK) |->
      (out_data_o.supply_millivolts == '0 && out_data_o.temp_decidegrees == '0))
    else $error("non-measurement result carries data");

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(EVENT_DEPTH)) else $error("event FIFO overfilled");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_res.done |-> state_q == SEQ_CALC) else $error("unexpected arithmetic done");

  a_calc_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEQ_CALC |-> mode_q == MODE_IDLE) else $error("mode not idle in measurement");
`endif

endmodule
